// File: rtl/rspd_pkg.sv
// rspd_pkg: shared types and codes for the remote serial protocol packet deframer
// holds the command record passed from the front end to the back end through the queue
// depends on nothing

package rspd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BREAK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NAK   = 2'd3;

    typedef enum logic [1:0] {
        OP_START,
        OP_ADD,
        OP_BREAK,
        OP_CHECK
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic              emit;
        logic              flip;
        logic              bad;
    } cmd_t;

endpackage

// File: rtl/rsp_packet_deframer_top.sv
// rsp_packet_deframer_top: top level of the remote serial protocol packet deframer
// depends on rspd_pkg, rspd_front, rspd_cmd_queue, rspd_back

// Takes one byte per cycle while full is low and passes one result per cycle at full rate. A
// received byte is classified by the framing state machine in the cycle of its transfer and,
// if it has any effect on the sum or gives a result, lands in a four-entry command queue; the
// back end takes one command per cycle unless a command that gives a result must wait for the
// held result to be popped, updates the running sum and loads the result register. full
// rises only when the command queue holds four commands, empty is low while the result
// register holds a result; bytes dropped while hunting and the closing hash give no result.

module rsp_packet_deframer_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [rspd_pkg::BYTE_W-1:0] rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [rspd_pkg::KIND_W-1:0] kind,
    output logic [rspd_pkg::BYTE_W-1:0] payload_byte,
    output logic [rspd_pkg::BYTE_W-1:0] sum_computed,
    output logic [rspd_pkg::BYTE_W-1:0] sum_received
);
    import rspd_pkg::*;

    logic in_take;
    logic cmd_valid;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_empty;
    logic q_rd;
    logic res_valid;
    logic res_take;

    assign full     = q_full;
    assign in_take  = push && !q_full;
    assign empty    = !res_valid;
    assign res_take = pop && res_valid;

    rspd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .rx_byte   (rx_byte),
        .cmd_valid (cmd_valid),
        .cmd       (front_cmd)
    );

    rspd_cmd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_cmd  (head_cmd),
        .q_empty (q_empty)
    );

    rspd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .q_empty      (q_empty),
        .q_rd         (q_rd),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .kind         (kind),
        .payload_byte (payload_byte),
        .sum_computed (sum_computed),
        .sum_received (sum_received)
    );

endmodule

// File: rtl/rspd_front.sv
// rspd_front: framing state machine that classifies each received byte into a command
// depends on rspd_pkg

module rspd_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_take,
    input  logic [rspd_pkg::BYTE_W-1:0] rx_byte,
    output logic                       cmd_valid,
    output rspd_pkg::cmd_t             cmd
);
    import rspd_pkg::*;

    localparam logic [BYTE_W-1:0] CH_START = 8'h24;
    localparam logic [BYTE_W-1:0] CH_END   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h7d;
    localparam logic [BYTE_W-1:0] CH_BREAK = 8'h03;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_HI   = 3'd3;
    localparam logic [2:0] PH_LO   = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       digit_bad_reg, digit_bad_next;
    logic [3:0] nib;
    logic       nib_bad;

    // hex digit decode, either case
    always_comb
    begin
        nib     = 4'hf;
        nib_bad = 1'b0;
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
        begin
            nib = rx_byte[3:0];
        end
        else if ((rx_byte >= 8'h61 && rx_byte <= 8'h66) ||
                 (rx_byte >= 8'h41 && rx_byte <= 8'h46))
        begin
            nib = rx_byte[3:0] + 4'd9;
        end
        else
        begin
            nib_bad = 1'b1;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        digit_bad_next   = digit_bad_reg;
        cmd_valid        = 1'b0;
        cmd.op           = OP_ADD;
        cmd.data         = rx_byte;
        cmd.emit         = 1'b0;
        cmd.flip         = 1'b0;
        cmd.bad          = 1'b0;
        unique case (phase_reg)
            PH_BODY:
            begin
                if (rx_byte == CH_END)
                begin
                    phase_next = PH_HI;
                end
                else if (rx_byte == CH_ESC)
                begin
                    phase_next = PH_ESC;
                    cmd_valid  = 1'b1;
                end
                else
                begin
                    cmd_valid = 1'b1;
                    cmd.emit  = 1'b1;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_BODY;
                cmd_valid  = 1'b1;
                cmd.emit   = 1'b1;
                cmd.flip   = 1'b1;
            end
            PH_HI:
            begin
                phase_next       = PH_LO;
                high_nibble_next = nib;
                digit_bad_next   = digit_bad_reg | nib_bad;
            end
            PH_LO:
            begin
                phase_next     = PH_HUNT;
                digit_bad_next = digit_bad_reg | nib_bad;
                cmd_valid      = 1'b1;
                cmd.op         = OP_CHECK;
                cmd.data       = {high_nibble_reg, nib};
                cmd.bad        = digit_bad_reg | nib_bad;
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (rx_byte == CH_START)
                begin
                    phase_next     = PH_BODY;
                    digit_bad_next = 1'b0;
                    cmd_valid      = 1'b1;
                    cmd.op         = OP_START;
                end
                else if (rx_byte == CH_BREAK)
                begin
                    cmd_valid = 1'b1;
                    cmd.op    = OP_BREAK;
                end
            end
        endcase
        if (!in_take)
        begin
            cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            high_nibble_reg <= 4'h0;
            digit_bad_reg   <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            digit_bad_reg   <= digit_bad_next;
        end
    end

endmodule

// File: rtl/rspd_cmd_queue.sv
// rspd_cmd_queue: short command queue between the front end and the back end
// depends on rspd_pkg

module rspd_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  rspd_pkg::cmd_t wr_cmd,
    output logic           q_full,
    input  logic           rd_en,
    output rspd_pkg::cmd_t rd_cmd,
    output logic           q_empty
);
    import rspd_pkg::*;

    cmd_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg, count_next;

    assign q_full  = (count_reg == QCW'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !wr_en)
        else $error("command written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !rd_en)
        else $error("command read from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/rspd_back.sv
// rspd_back: executes commands, keeps the running body sum and holds the result register
// depends on rspd_pkg

module rspd_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rspd_pkg::cmd_t              cmd,
    input  logic                        q_empty,
    output logic                        q_rd,
    output logic                        res_valid,
    input  logic                        res_take,
    output logic [rspd_pkg::KIND_W-1:0] kind,
    output logic [rspd_pkg::BYTE_W-1:0] payload_byte,
    output logic [rspd_pkg::BYTE_W-1:0] sum_computed,
    output logic [rspd_pkg::BYTE_W-1:0] sum_received
);
    import rspd_pkg::*;

    localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;

    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              valid_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] pay_reg, pay_next;
    logic [BYTE_W-1:0] sc_reg, sc_next;
    logic [BYTE_W-1:0] sr_reg, sr_next;
    logic              gives_result;
    logic              slot_free;
    logic [BYTE_W-1:0] sum_add;

    assign sum_add      = sum_reg + cmd.data;
    assign gives_result = (cmd.op == OP_BREAK) || (cmd.op == OP_CHECK) ||
                          ((cmd.op == OP_ADD) && cmd.emit);
    assign slot_free    = !valid_reg || res_take;
    assign q_rd         = !q_empty && (slot_free || !gives_result);

    always_comb
    begin
        sum_next  = sum_reg;
        kind_next = KIND_DATA;
        pay_next  = '0;
        sc_next   = '0;
        sr_next   = '0;
        unique case (cmd.op)
            OP_START:
            begin
                sum_next = '0;
            end
            OP_ADD:
            begin
                sum_next = sum_add;
                pay_next = cmd.flip ? (cmd.data ^ ESC_XOR) : cmd.data;
                sc_next  = sum_add;
            end
            OP_BREAK:
            begin
                kind_next = KIND_BREAK;
            end
            OP_CHECK:
            begin
                kind_next = (!cmd.bad && (cmd.data == sum_reg)) ? KIND_ACK : KIND_NAK;
                sc_next   = sum_reg;
                sr_next   = cmd.data;
            end
            default:
            begin
                sum_next = sum_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_rd)
            begin
                sum_reg <= sum_next;
            end
            if (q_rd && gives_result)
            begin
                valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd && gives_result)
        begin
            kind_reg <= kind_next;
            pay_reg  <= pay_next;
            sc_reg   <= sc_next;
            sr_reg   <= sr_next;
        end
    end

    assign res_valid    = valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = pay_reg;
    assign sum_computed = sc_reg;
    assign sum_received = sr_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !res_take && q_rd) |-> !gives_result)
        else $error("held result overwritten");

    a_ack_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_ACK) |-> (sc_reg == sr_reg))
        else $error("ack with differing sums");

    a_break_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_BREAK) |-> (sc_reg == '0 && sr_reg == '0))
        else $error("break result carries sums");
`endif

endmodule

// File: tb/rsp_packet_deframer_top_tb.sv
// rsp_packet_deframer_top_tb: self-checking testbench for the packet deframer top level
// drives received bytes through the push side, predicts every result and checks each pop
// depends on rspd_pkg and rsp_packet_deframer_top
`timescale 1ns / 100ps

module rsp_packet_deframer_top_tb;

    import rspd_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [7:0] SOF_CHAR    = 8'h24;
    localparam logic [7:0] EOF_CHAR    = 8'h23;
    localparam logic [7:0] ESC_CHAR    = 8'h7d;
    localparam logic [7:0] BRK_CHAR    = 8'h03;
    localparam logic [7:0] ESC_FLIP    = 8'h20;

    typedef enum logic [2:0] {
        FR_HUNT,
        FR_BODY,
        FR_ESCAPE,
        FR_SUM_HI,
        FR_SUM_LO
    } frame_phase_e;

    typedef enum logic [1:0] {
        SUM_GOOD,
        SUM_WRONG,
        SUM_JUNK
    } sum_mode_e;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        payload;
        logic [7:0]        sum_c;
        logic [7:0]        sum_r;
    } frame_result_t;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              push         = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] rx_byte      = '0;
    logic              empty;
    logic              pop          = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] sum_computed;
    logic [BYTE_W-1:0] sum_received;

    frame_phase_e      fr_phase     = FR_HUNT;
    logic [7:0]        fr_sum       = '0;
    logic [3:0]        fr_hi        = '0;
    logic              fr_digit_bad = 1'b0;
    frame_result_t     deframed_q[$];

    int                tx_gap_pct   = 19;
    int                rx_stall_pct = 71;
    int                counted      = 0;
    int                err_count    = 0;
    int                cycle_count  = 0;

    rsp_packet_deframer_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .payload_byte (payload_byte),
        .sum_computed (sum_computed),
        .sum_received (sum_received)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rsp_packet_deframer_top_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h1f;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // returns 0 for a byte dropped while hunting
    function automatic logic deframe_byte(input logic [7:0] b);
        frame_result_t r;
        logic [4:0]    d;
        logic          got;
        logic          used;
        r    = '0;
        got  = 1'b0;
        used = 1'b1;
        case (fr_phase)
            FR_BODY:
            begin
                if (b == EOF_CHAR)
                    fr_phase = FR_SUM_HI;
                else
                begin
                    fr_sum = fr_sum + b;
                    if (b == ESC_CHAR)
                        fr_phase = FR_ESCAPE;
                    else
                    begin
                        r.kind    = KIND_DATA;
                        r.payload = b;
                        r.sum_c   = fr_sum;
                        got       = 1'b1;
                    end
                end
            end
            FR_ESCAPE:
            begin
                fr_sum    = fr_sum + b;
                fr_phase  = FR_BODY;
                r.kind    = KIND_DATA;
                r.payload = b ^ ESC_FLIP;
                r.sum_c   = fr_sum;
                got       = 1'b1;
            end
            FR_SUM_HI:
            begin
                d = hex_nibble(b);
                if (d[4])
                    fr_digit_bad = 1'b1;
                fr_hi    = d[3:0];
                fr_phase = FR_SUM_LO;
            end
            FR_SUM_LO:
            begin
                d = hex_nibble(b);
                if (d[4])
                    fr_digit_bad = 1'b1;
                r.sum_r  = {fr_hi, d[3:0]};
                r.sum_c  = fr_sum;
                r.kind   = (!fr_digit_bad && r.sum_r == fr_sum) ? KIND_ACK : KIND_NAK;
                got      = 1'b1;
                fr_phase = FR_HUNT;
            end
            default:
            begin
                fr_phase = FR_HUNT;
                if (b == SOF_CHAR)
                begin
                    fr_phase     = FR_BODY;
                    fr_sum       = '0;
                    fr_digit_bad = 1'b0;
                end
                else if (b == BRK_CHAR)
                begin
                    r.kind = KIND_BREAK;
                    got    = 1'b1;
                end
                else
                    used = 1'b0;
            end
        endcase
        if (got)
            deframed_q.push_back(r);
        return used;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    task automatic check_result();
        frame_result_t e;
        if (deframed_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d", kind));
            return;
        end
        e = deframed_q.pop_front();
        if (kind !== e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
        if (payload_byte !== e.payload)
            report_mismatch($sformatf("payload_byte %02h, want %02h", payload_byte, e.payload));
        if (sum_computed !== e.sum_c)
            report_mismatch($sformatf("sum_computed %02h, want %02h", sum_computed, e.sum_c));
        if (sum_received !== e.sum_r)
            report_mismatch($sformatf("sum_received %02h, want %02h", sum_received, e.sum_r));
    endtask

    // result side: one transfer per edge with pop high and empty low
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_result();
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (deframe_byte(b))
            counted++;
    endtask

    task automatic send_checksum(input sum_mode_e mode);
        logic [7:0] v;
        v = fr_sum;
        if (mode == SUM_WRONG)
            v = fr_sum ^ 8'($urandom_range(1, 255));
        if (mode == SUM_JUNK)
        begin
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
        end
        else
        begin
            send_byte(hex_char(v[7:4], 1'($urandom_range(1))));
            send_byte(hex_char(v[3:0], 1'($urandom_range(1))));
        end
    endtask

    task automatic send_random_frame();
        int         len;
        int         r;
        logic [7:0] b;
        if ($urandom_range(3) == 0)
            send_byte(BRK_CHAR);
        if ($urandom_range(3) == 0)
            send_byte(8'($urandom_range(255)));
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
        send_byte(SOF_CHAR);
        repeat (len)
        begin
            b = 8'($urandom_range(255));
            if (b == EOF_CHAR || $urandom_range(7) == 0)
            begin
                send_byte(ESC_CHAR);
                send_byte(b ^ ESC_FLIP);
            end
            else
                send_byte(b);
        end
        send_byte(EOF_CHAR);
        r = $urandom_range(99);
        send_checksum(r < 80 ? SUM_GOOD : (r < 90 ? SUM_WRONG : SUM_JUNK));
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(5))
                0:       b = BRK_CHAR;
                1:       b = SOF_CHAR;
                2:       b = EOF_CHAR;
                3:       b = ESC_CHAR;
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b);
        end
    endtask

    task automatic run_traffic(input int target);
        int base;
        base = counted;
        while (counted - base < target)
        begin
            if ($urandom_range(99) < 75)
                send_random_frame();
            else
                send_noise();
        end
    endtask

    // break request and bytes dropped while hunting
    task automatic test_hunting();
        send_byte(BRK_CHAR);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(EOF_CHAR);
    endtask

    // extremes, dollar inside the body, escaped brace and escaped break byte
    task automatic test_good_frame();
        send_byte(SOF_CHAR);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(SOF_CHAR);
        send_byte(ESC_CHAR);
        send_byte(ESC_CHAR);
        send_byte(ESC_CHAR);
        send_byte(BRK_CHAR);
        send_byte(EOF_CHAR);
        send_checksum(SUM_GOOD);
    endtask

    // invalid low digit with matching sums, then empty body with invalid high digit
    task automatic test_bad_digits();
        send_byte(SOF_CHAR);
        send_byte(8'hff);
        send_byte(EOF_CHAR);
        send_byte(8'h66);
        send_byte(8'h5a);
        send_byte(SOF_CHAR);
        send_byte(EOF_CHAR);
        send_byte(8'h5a);
        send_byte(8'h30);
    endtask

    task automatic test_traffic_slow_receiver();
        tx_gap_pct   = 19;
        rx_stall_pct = 71;
        run_traffic(583);
    endtask

    task automatic test_traffic_slow_sender();
        tx_gap_pct   = 71;
        rx_stall_pct = 19;
        run_traffic(583);
    endtask

    task automatic test_traffic_full_rate();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_traffic(584);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hunting();
        test_good_frame();
        test_bad_digits();
        test_traffic_slow_receiver();
        test_traffic_slow_sender();
        test_traffic_full_rate();
        push <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("rsp_packet_deframer_top_tb OK");
        else
            $display("rsp_packet_deframer_top_tb NOT OK");
        $finish;
    end

endmodule
